@@ src/atc_pkg.sv @@
// shared types and constants for the cubic atan2 pipeline
// no dependencies
`timescale 1ns / 1ps

package atc_pkg;

    localparam int FIELD_W = 16;
    localparam int ANGLE_W = 9;

    localparam logic signed [9:0] ANG_BASE_RIGHT = 10'sd45;
    localparam logic signed [9:0] ANG_BASE_LEFT  = 10'sd135;
    localparam logic signed [9:0] ANG_HALF_TURN  = 10'sd180;

    localparam logic signed [7:0] COEF_LIN = -8'sd56;
    localparam logic signed [7:0] COEF_CUB = 8'sd11;

    typedef struct packed {
        logic yzero;
        logic yneg;
        logic xneg;
        logic qneg;
    } t_side;

endpackage

@@ src/atc_prep.sv @@
// input stage: sign extension, |y|, numerator magnitude and divisor
// depends on atc_pkg
`timescale 1ns / 1ps

module atc_prep import atc_pkg::*; #(
    parameter int INPUT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [FIELD_W-1:0]     i_y_value,
    input  logic [FIELD_W-1:0]     i_x_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [INPUT_WIDTH:0]   o_num_mag,
    output logic [INPUT_WIDTH:0]   o_den,
    output t_side                  o_side
);

    localparam int IW = INPUT_WIDTH;

    logic signed [IW+1:0] y_ext;
    logic signed [IW+1:0] x_ext;
    logic signed [IW+1:0] ay;
    logic signed [IW+1:0] num;
    logic signed [IW+1:0] num_neg;
    logic signed [IW+1:0] den;

    logic          r_valid;
    logic [IW:0]   r_num_mag;
    logic [IW:0]   r_den;
    t_side         r_side;
    logic [IW:0]   n_num_mag;
    t_side         n_side;

    always_comb begin
        y_ext = {{2{i_y_value[IW-1]}}, i_y_value[IW-1:0]};
        x_ext = {{2{i_x_value[IW-1]}}, i_x_value[IW-1:0]};
        ay    = y_ext[IW+1] ? -y_ext : y_ext;
        if (x_ext[IW+1]) begin
            num = x_ext + ay;
            den = ay - x_ext;
        end else begin
            num = x_ext - ay;
            den = x_ext + ay;
        end
        num_neg   = -num;
        n_num_mag = num[IW+1] ? num_neg[IW:0] : num[IW:0];
        n_side.yzero = (y_ext == '0);
        n_side.yneg  = y_ext[IW+1];
        n_side.xneg  = x_ext[IW+1];
        n_side.qneg  = num[IW+1];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_num_mag <= n_num_mag;
            r_den     <= den[IW:0];
            r_side    <= n_side;
        end
    end

    assign o_valid   = r_valid;
    assign o_num_mag = r_num_mag;
    assign o_den     = r_den;
    assign o_side    = r_side;

    // ratio magnitude never exceeds one
    a_mag_le_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_side.yzero |-> r_num_mag <= r_den)
        else $error("numerator magnitude above divisor");

endmodule

@@ src/atc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on atc_pkg
`timescale 1ns / 1ps

module atc_div import atc_pkg::*; #(
    parameter int INPUT_WIDTH = 16,
    parameter int FRAC_BITS   = 15
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [INPUT_WIDTH:0]   i_num_mag,
    input  logic [INPUT_WIDTH:0]   i_den,
    input  t_side                  i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [FRAC_BITS:0]     o_q,
    output t_side                  o_side
);

    localparam int IW = INPUT_WIDTH;
    localparam int F  = FRAC_BITS;

    logic          r_v    [0:F];
    logic [IW:0]   r_rem  [0:F];
    logic [IW:0]   r_den  [0:F];
    logic [F:0]    r_q    [0:F];
    t_side         r_side [0:F];
    logic          rdy    [0:F+1];

    assign rdy[F+1] = i_ready;

    for (genvar k = 0; k <= F; k++) begin : g_stage
        logic          v_in;
        logic [IW:0]   rem_in;
        logic [IW:0]   den_in;
        logic [F:0]    q_in;
        t_side         side_in;
        logic [IW+1:0] trial;
        logic [IW+1:0] diff;
        logic          ge;
        logic [IW:0]   n_rem;
        logic [F:0]    n_q;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_num_mag;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign side_in = i_side;
            assign trial   = {1'b0, rem_in};
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
            assign trial   = {rem_in, 1'b0};
        end

        assign diff   = trial - {1'b0, den_in};
        assign ge     = (trial >= {1'b0, den_in});
        assign n_rem  = ge ? diff[IW:0] : trial[IW:0];
        assign n_q    = {q_in[F-1:0], ge};
        assign rdy[k] = !r_v[k] || rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= den_in;
                r_q[k]    <= n_q;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[F];
    assign o_q     = r_q[F];
    assign o_side  = r_side[F];

    // quotient bounded by one in fixed point
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[F] && !r_side[F].yzero |-> r_q[F] <= ((F+1)'(1) << F))
        else $error("quotient above one");

    // remainder always below divisor after the last step
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[F] && !r_side[F].yzero |-> r_rem[F] < r_den[F])
        else $error("remainder not reduced");

endmodule

@@ src/atc_poly.sv @@
// cubic correction, base offset, sign and special cases, output register
// depends on atc_pkg
`timescale 1ns / 1ps

module atc_poly import atc_pkg::*; #(
    parameter int FRAC_BITS = 15
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [FRAC_BITS:0]     i_q,
    input  t_side                  i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [ANGLE_W-1:0]     o_angle_deg
);

    localparam int F = FRAC_BITS;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    t_side r_side1, r_side2, r_side3, r_side4;

    logic signed [F+1:0]   q_ext;
    logic signed [F+1:0]   n_r;
    logic signed [F+1:0]   r_r1;
    logic signed [2*F+3:0] p_sq;
    logic signed [F+1:0]   r_sq2;
    logic signed [F+1:0]   r_r2;
    logic signed [2*F+3:0] p_cub;
    logic signed [F+1:0]   r_cub3;
    logic signed [F+6:0]   n_lin;
    logic signed [F+6:0]   r_lin3;
    logic signed [F+4:0]   c11;
    logic signed [F+7:0]   n_t;
    logic signed [F+7:0]   r_t4;
    logic signed [7:0]     corr;
    logic signed [9:0]     base;
    logic signed [9:0]     ang;
    logic signed [9:0]     ang_neg;
    logic signed [9:0]     n_res;
    logic [ANGLE_W-1:0]    r_angle;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // signed ratio
    always_comb begin
        q_ext = {1'b0, i_q};
        n_r   = i_side.qneg ? -q_ext : q_ext;
    end

    assign p_sq  = r_r1 * r_r1;
    assign p_cub = r_sq2 * r_r2;
    assign n_lin = r_r2 * COEF_LIN;
    assign c11   = r_cub3 * COEF_CUB;
    assign n_t   = c11 + r_lin3;

    always_comb begin
        corr    = r_t4[F+7:F];
        base    = r_side4.xneg ? ANG_BASE_LEFT : ANG_BASE_RIGHT;
        ang     = base + corr;
        ang_neg = -ang;
        if (r_side4.yzero) begin
            n_res = r_side4.xneg ? ANG_HALF_TURN : '0;
        end else begin
            n_res = r_side4.yneg ? ang_neg : ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_r1    <= n_r;
            r_side1 <= i_side;
        end
        if (rdy2) begin
            r_sq2   <= p_sq[2*F+1:F];
            r_r2    <= r_r1;
            r_side2 <= r_side1;
        end
        if (rdy3) begin
            r_cub3  <= p_cub[2*F+1:F];
            r_lin3  <= n_lin;
            r_side3 <= r_side2;
        end
        if (rdy4) begin
            r_t4    <= n_t;
            r_side4 <= r_side3;
        end
        if (rdy5) begin
            r_angle <= n_res[ANGLE_W-1:0];
        end
    end

    assign o_valid     = r_v5;
    assign o_angle_deg = r_angle;

    // angle stays within a half turn either way
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> ($signed(r_angle) >= -9'sd180) && ($signed(r_angle) <= 9'sd180))
        else $error("angle out of range");

endmodule

@@ src/atan2_cubic_1deg_top.sv @@
// top level of the cubic atan2 pipeline: prep, divider, polynomial
// depends on atc_pkg, atc_prep, atc_div, atc_poly
//
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_y_value, i_x_value
// output  | out       | o_out_valid / i_out_ready  | o_angle_deg
//
// one transaction per clock sustained while the output is accepted (i_out_ready high)
// the divider resolves one quotient bit per stage, FRAC_BITS + 1 stages
// every stage holds its own valid bit; a stage loads when it is empty or its successor moves
// a stalled output only backs up the stages that hold data; bubbles are filled
// synchronous active-low reset clears all valid bits, data registers are not reset
`timescale 1ns / 1ps

module atan2_cubic_1deg_top import atc_pkg::*; #(
    parameter int INPUT_WIDTH = 16,
    parameter int FRAC_BITS   = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [FIELD_W-1:0]  i_y_value,
    input  logic [FIELD_W-1:0]  i_x_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ANGLE_W-1:0]  o_angle_deg
);

    logic                  prep_valid;
    logic                  prep_ready;
    logic [INPUT_WIDTH:0]  prep_num_mag;
    logic [INPUT_WIDTH:0]  prep_den;
    t_side                 prep_side;
    logic                  div_valid;
    logic                  div_ready;
    logic [FRAC_BITS:0]    div_q;
    t_side                 div_side;

    atc_prep #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_y_value (i_y_value),
        .i_x_value (i_x_value),
        .o_valid   (prep_valid),
        .i_ready   (prep_ready),
        .o_num_mag (prep_num_mag),
        .o_den     (prep_den),
        .o_side    (prep_side)
    );

    atc_div #(
        .INPUT_WIDTH (INPUT_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (prep_valid),
        .o_ready   (prep_ready),
        .i_num_mag (prep_num_mag),
        .i_den     (prep_den),
        .i_side    (prep_side),
        .o_valid   (div_valid),
        .i_ready   (div_ready),
        .o_q       (div_q),
        .o_side    (div_side)
    );

    atc_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (div_valid),
        .o_ready     (div_ready),
        .i_q         (div_q),
        .i_side      (div_side),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_angle_deg (o_angle_deg)
    );

endmodule
